/* rtl/desm_pkg.sv */
// Shared types, opcodes, error codes and word layouts of the DWARF expression stack machine.
package desm_pkg;

  localparam int DEFAULT_STACK_DEPTH = 64;

  localparam int VALUE_W     = 64;
  localparam int CMD_W       = 8;
  localparam int ERR_W       = 3;
  localparam int COUNT_OUT_W = 7;
  localparam int HALF_W      = VALUE_W / 2;

  // s_tdata: command, operand, external_value, clear_stack, zero pad
  localparam int IN_CMD_LSB   = 0;
  localparam int IN_OPND_LSB  = IN_CMD_LSB + CMD_W;
  localparam int IN_EXT_LSB   = IN_OPND_LSB + VALUE_W;
  localparam int IN_CLR_BIT   = IN_EXT_LSB + VALUE_W;
  localparam int IN_USED_W    = IN_CLR_BIT + 1;
  localparam int IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;

  // m_tdata: top_value, stack_count, error_code, zero pad
  localparam int OUT_USED_W   = VALUE_W + COUNT_OUT_W + ERR_W;
  localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  localparam int CFG_IDX_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FBREG_BASE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OBJECT_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HAS_OBJECT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HAS_CURSOR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HAS_ADDR_SPACE = 3'd4;

  localparam logic [CMD_W-1:0] OP_ADDR        = 8'h03;
  localparam logic [CMD_W-1:0] OP_DEREF       = 8'h06;
  localparam logic [CMD_W-1:0] OP_CONST_LO    = 8'h08;
  localparam logic [CMD_W-1:0] OP_CONST_HI    = 8'h11;
  localparam logic [CMD_W-1:0] OP_DUP         = 8'h12;
  localparam logic [CMD_W-1:0] OP_DROP        = 8'h13;
  localparam logic [CMD_W-1:0] OP_OVER        = 8'h14;
  localparam logic [CMD_W-1:0] OP_SWAP        = 8'h16;
  localparam logic [CMD_W-1:0] OP_AND         = 8'h1a;
  localparam logic [CMD_W-1:0] OP_MINUS       = 8'h1c;
  localparam logic [CMD_W-1:0] OP_MUL         = 8'h1e;
  localparam logic [CMD_W-1:0] OP_NEG         = 8'h1f;
  localparam logic [CMD_W-1:0] OP_NOT         = 8'h20;
  localparam logic [CMD_W-1:0] OP_OR          = 8'h21;
  localparam logic [CMD_W-1:0] OP_PLUS        = 8'h22;
  localparam logic [CMD_W-1:0] OP_PLUS_UCONST = 8'h23;
  localparam logic [CMD_W-1:0] OP_XOR         = 8'h27;
  localparam logic [CMD_W-1:0] OP_LIT_LO      = 8'h30;
  localparam logic [CMD_W-1:0] OP_LIT_HI      = 8'h4f;
  localparam logic [CMD_W-1:0] OP_BREG_LO     = 8'h70;
  localparam logic [CMD_W-1:0] OP_BREG_HI     = 8'h8f;
  localparam logic [CMD_W-1:0] OP_FBREG       = 8'h91;
  localparam logic [CMD_W-1:0] OP_NOP         = 8'h96;
  localparam logic [CMD_W-1:0] OP_CFA         = 8'h9c;

  localparam logic [ERR_W-1:0] ERR_OK          = 3'd0;
  localparam logic [ERR_W-1:0] ERR_NO_CFA      = 3'd1;
  localparam logic [ERR_W-1:0] ERR_NO_BASE     = 3'd2;
  localparam logic [ERR_W-1:0] ERR_NO_MEM      = 3'd3;
  localparam logic [ERR_W-1:0] ERR_UNSUPPORTED = 3'd4;
  localparam logic [ERR_W-1:0] ERR_NO_BREG     = 3'd5;
  localparam logic [ERR_W-1:0] ERR_UNDER       = 3'd6;
  localparam logic [ERR_W-1:0] ERR_OVER        = 3'd7;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_UP,
    SH_DOWN
  } shift_t;

  typedef enum logic [2:0] {
    K_NONE,
    K_PUSH,
    K_DROP,
    K_BINARY,
    K_SWAP,
    K_UNARY,
    K_MUL
  } op_kind_t;

  typedef enum logic [1:0] {
    MUL_IDLE,
    MUL_CROSS_A,
    MUL_CROSS_B
  } mul_state_t;

  typedef struct packed {
    logic run;
    logic done;
  } mul_status_t;

endpackage

/* rtl/dwarf_expression_stack_machine.sv */
// Top level of the DWARF expression stack machine.
// Executes one DWARF operation per input word on a stack held in a row of STACK_DEPTH cells,
// top entry in cell 0; every operation other than mul updates the stack as its word is taken,
// so words stream in back to back unless the output buffer is full or a mul runs. mul runs on a
// shared 32x32 multiplier and holds s_tready low while it runs. Each accepted word gives one
// result word; a two-deep output buffer lets the input keep moving while one result waits, and
// the input stalls once two results wait. Configuration writes are taken every cycle.
module dwarf_expression_stack_machine import desm_pkg::*; #(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // command, operand, external_value, clear_stack
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // top_value, stack_count, error_code
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [VALUE_W-1:0]    cfg_data
);

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  logic [VALUE_W-1:0] fbreg_base, object_base;
  logic               has_object_info, has_cursor, has_address_space;

  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] cell_q [STACK_DEPTH];
  shift_t             mode_first, mode_second, mode_rest;
  logic [VALUE_W-1:0] top_in;

  logic [CMD_W-1:0]   cmd;
  logic [VALUE_W-1:0] operand, ext;
  logic               clr;
  logic [CNT_W-1:0]   ce;
  logic               has1, has2, full;
  op_kind_t           kind;
  logic [ERR_W-1:0]   err;
  logic [VALUE_W-1:0] push_val, bin_val, un_val, base_val, base_sum;
  logic [VALUE_W-1:0] new_top;
  logic [CNT_W-1:0]   new_cnt;

  logic               fire, m_pop, res_valid, mul_start, mul_last;
  mul_status_t        mul_st;
  logic [VALUE_W-1:0] mul_prod;
  logic [OUT_DATA_W-1:0] res_data, skid_data;
  logic               res_last, skid_last, skid_valid;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      fbreg_base        <= '0;
      object_base       <= '0;
      has_object_info   <= 1'b0;
      has_cursor        <= 1'b0;
      has_address_space <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FBREG_BASE:     fbreg_base        <= cfg_data;
        REG_OBJECT_BASE:    object_base       <= cfg_data;
        REG_HAS_OBJECT:     has_object_info   <= cfg_data[0];
        REG_HAS_CURSOR:     has_cursor        <= cfg_data[0];
        REG_HAS_ADDR_SPACE: has_address_space <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign cmd     = s_tdata[IN_CMD_LSB +: CMD_W];
  assign operand = s_tdata[IN_OPND_LSB +: VALUE_W];
  assign ext     = s_tdata[IN_EXT_LSB +: VALUE_W];
  assign clr     = s_tdata[IN_CLR_BIT];

  assign ce   = clr ? '0 : cnt;
  assign has1 = ce != '0;
  assign has2 = ce > CNT_W'(1);
  assign full = ce == CNT_W'(STACK_DEPTH);

  always_comb begin
    case (cmd) inside
      [OP_BREG_LO:OP_BREG_HI]: base_val = ext;
      OP_FBREG:                base_val = fbreg_base;
      default:                 base_val = object_base;
    endcase
  end

  assign base_sum = base_val + operand;

  always_comb begin
    case (cmd)
      OP_AND:   bin_val = cell_q[0] & cell_q[1];
      OP_MINUS: bin_val = cell_q[1] - cell_q[0];
      OP_OR:    bin_val = cell_q[0] | cell_q[1];
      OP_PLUS:  bin_val = cell_q[0] + cell_q[1];
      default:  bin_val = cell_q[0] ^ cell_q[1];
    endcase
  end

  always_comb begin
    case (cmd)
      OP_NEG:         un_val = '0 - cell_q[0];
      OP_NOT:         un_val = ~cell_q[0];
      OP_PLUS_UCONST: un_val = cell_q[0] + operand;
      default:        un_val = ext;
    endcase
  end

  always_comb begin
    kind     = K_NONE;
    err      = ERR_OK;
    push_val = base_sum;
    case (cmd) inside
      [OP_LIT_LO:OP_LIT_HI]: begin
        kind     = K_PUSH;
        push_val = VALUE_W'(cmd - OP_LIT_LO);
      end
      [OP_CONST_LO:OP_CONST_HI]: begin
        kind     = K_PUSH;
        push_val = operand;
      end
      [OP_BREG_LO:OP_BREG_HI]: begin
        if (!has_cursor) err = ERR_NO_BREG;
        else kind = K_PUSH;
      end
      OP_CFA: begin
        push_val = ext;
        if (!has_cursor) err = ERR_NO_CFA;
        else kind = K_PUSH;
      end
      OP_FBREG: kind = K_PUSH;
      OP_ADDR: begin
        if (!has_object_info) err = ERR_NO_BASE;
        else kind = K_PUSH;
      end
      OP_DUP: begin
        push_val = cell_q[0];
        if (!has1) err = ERR_UNDER;
        else kind = K_PUSH;
      end
      OP_DROP: begin
        if (!has1) err = ERR_UNDER;
        else kind = K_DROP;
      end
      OP_OVER: begin
        push_val = cell_q[1];
        if (!has2) err = ERR_UNDER;
        else kind = K_PUSH;
      end
      OP_SWAP: begin
        if (!has2) err = ERR_UNDER;
        else kind = K_SWAP;
      end
      OP_AND, OP_MINUS, OP_OR, OP_PLUS, OP_XOR: begin
        if (!has2) err = ERR_UNDER;
        else kind = K_BINARY;
      end
      OP_MUL: begin
        if (!has2) err = ERR_UNDER;
        else kind = K_MUL;
      end
      OP_NEG, OP_NOT, OP_PLUS_UCONST: begin
        if (!has1) err = ERR_UNDER;
        else kind = K_UNARY;
      end
      OP_DEREF: begin
        if (!has_address_space) err = ERR_NO_MEM;
        else if (!has1) err = ERR_UNDER;
        else kind = K_UNARY;
      end
      OP_NOP: begin
      end
      default: err = ERR_UNSUPPORTED;
    endcase
    if (kind == K_PUSH && full) begin
      kind = K_NONE;
      err  = ERR_OVER;
    end
  end

  always_comb begin
    new_cnt = ce;
    case (kind)
      K_PUSH: begin
        new_top = push_val;
        new_cnt = ce + CNT_W'(1);
      end
      K_DROP: begin
        new_top = has2 ? cell_q[1] : '0;
        new_cnt = ce - CNT_W'(1);
      end
      K_BINARY: begin
        new_top = bin_val;
        new_cnt = ce - CNT_W'(1);
      end
      K_SWAP:  new_top = cell_q[1];
      K_UNARY: new_top = un_val;
      default: new_top = has1 ? cell_q[0] : '0;
    endcase
  end

  assign s_tready  = !skid_valid && !mul_st.run;
  assign fire      = s_tvalid && s_tready;
  assign mul_start = fire && kind == K_MUL;
  assign m_pop     = m_tvalid && m_tready;
  assign res_valid = (fire && kind != K_MUL) || mul_st.done;

  desm_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (cell_q[0]),
    .b       (cell_q[1]),
    .status  (mul_st),
    .product (mul_prod)
  );

  always_ff @(posedge clk) begin
    if (mul_start) mul_last <= s_tlast;
  end

  always_comb begin
    mode_first  = SH_HOLD;
    mode_second = SH_HOLD;
    mode_rest   = SH_HOLD;
    top_in      = un_val;
    if (mul_st.done) begin
      mode_first  = SH_UP;
      mode_second = SH_DOWN;
      mode_rest   = SH_DOWN;
      top_in      = mul_prod;
    end else if (fire) begin
      case (kind)
        K_PUSH: begin
          mode_first  = SH_UP;
          mode_second = SH_UP;
          mode_rest   = SH_UP;
          top_in      = push_val;
        end
        K_DROP: begin
          mode_first  = SH_DOWN;
          mode_second = SH_DOWN;
          mode_rest   = SH_DOWN;
        end
        K_BINARY: begin
          mode_first  = SH_UP;
          mode_second = SH_DOWN;
          mode_rest   = SH_DOWN;
          top_in      = bin_val;
        end
        K_SWAP: begin
          mode_first  = SH_DOWN;
          mode_second = SH_UP;
        end
        K_UNARY: mode_first = SH_UP;
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    shift_t             mode;
    logic [VALUE_W-1:0] up_val, down_val;
    if (i == 0) begin : g_first
      assign mode   = mode_first;
      assign up_val = top_in;
    end else if (i == 1) begin : g_second
      assign mode   = mode_second;
      assign up_val = cell_q[i-1];
    end else begin : g_rest
      assign mode   = mode_rest;
      assign up_val = cell_q[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign down_val = cell_q[i];
    end else begin : g_inner
      assign down_val = cell_q[i+1];
    end
    desm_cell u_cell (
      .clk      (clk),
      .mode     (mode),
      .up_val   (up_val),
      .down_val (down_val),
      .value    (cell_q[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (mul_st.done) begin
      cnt <= cnt - CNT_W'(1);
    end else if (fire) begin
      cnt <= new_cnt;
    end
  end

  always_comb begin
    res_data = '0;
    if (mul_st.done) begin
      res_data[VALUE_W-1:0]                = mul_prod;
      res_data[VALUE_W +: COUNT_OUT_W]     = COUNT_OUT_W'(cnt - CNT_W'(1));
      res_data[VALUE_W+COUNT_OUT_W +: ERR_W] = ERR_OK;
      res_last = mul_last;
    end else begin
      res_data[VALUE_W-1:0]                = new_top;
      res_data[VALUE_W +: COUNT_OUT_W]     = COUNT_OUT_W'(new_cnt);
      res_data[VALUE_W+COUNT_OUT_W +: ERR_W] = err;
      res_last = s_tlast && err == ERR_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (res_valid) begin
      if (!m_tvalid || m_pop) m_tvalid <= 1'b1;
      else skid_valid <= 1'b1;
    end else if (m_pop) begin
      m_tvalid   <= skid_valid;
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      if (!m_tvalid || m_pop) begin
        m_tdata <= res_data;
        m_tlast <= res_last;
      end else begin
        skid_data <= res_data;
        skid_last <= res_last;
      end
    end else if (m_pop) begin
      m_tdata <= skid_data;
      m_tlast <= skid_last;
    end
  end

endmodule

/* rtl/desm_cell.sv */
// One stack entry: holds, takes the entry above it, or takes the entry below it.
module desm_cell import desm_pkg::*; (
  input  logic               clk,
  input  shift_t             mode,
  input  logic [VALUE_W-1:0] up_val,
  input  logic [VALUE_W-1:0] down_val,
  output logic [VALUE_W-1:0] value
);

  always_ff @(posedge clk) begin
    case (mode)
      SH_UP:   value <= up_val;
      SH_DOWN: value <= down_val;
      SH_HOLD: value <= value;
      default: value <= value;
    endcase
  end

endmodule

/* rtl/desm_mul.sv */
// Low 64 bits of a 64x64 product on one 32x32 multiplier: low halves first, then the cross products.
module desm_mul import desm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [VALUE_W-1:0] a,
  input  logic [VALUE_W-1:0] b,
  output mul_status_t        status,
  output logic [VALUE_W-1:0] product
);

  mul_state_t          state, state_next;
  logic [HALF_W-1:0]   mx_a, mx_b;
  logic [VALUE_W-1:0]  prod;
  logic [VALUE_W-1:0]  acc;

  always_comb begin
    state_next = state;
    case (state)
      MUL_IDLE:    if (start) state_next = MUL_CROSS_A;
      MUL_CROSS_A: state_next = MUL_CROSS_B;
      MUL_CROSS_B: state_next = MUL_IDLE;
      default:     state_next = MUL_IDLE;
    endcase
  end

  always_comb begin
    mx_a = a[HALF_W-1:0];
    mx_b = b[HALF_W-1:0];
    status.run  = 1'b0;
    status.done = 1'b0;
    case (state)
      MUL_IDLE: begin
      end
      MUL_CROSS_A: begin
        mx_b = b[VALUE_W-1:HALF_W];
        status.run = 1'b1;
      end
      MUL_CROSS_B: begin
        mx_a = a[VALUE_W-1:HALF_W];
        status.run  = 1'b1;
        status.done = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign prod    = VALUE_W'(mx_a) * VALUE_W'(mx_b);
  assign product = {acc[VALUE_W-1:HALF_W] + prod[HALF_W-1:0], acc[HALF_W-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MUL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == MUL_IDLE && start) begin
      acc <= prod;
    end else if (state == MUL_CROSS_A) begin
      acc[VALUE_W-1:HALF_W] <= acc[VALUE_W-1:HALF_W] + prod[HALF_W-1:0];
    end
  end

endmodule

/* rtl/desm_checker.sv */
// Port-level checks of the DWARF expression stack machine, bound to the top level.
module desm_checker import desm_pkg::*; #(
  parameter int STACK_DEPTH = DEFAULT_STACK_DEPTH
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic                  m_tlast
);

  logic [VALUE_W-1:0]     top_value;
  logic [COUNT_OUT_W-1:0] stack_count;
  logic [ERR_W-1:0]       error_code;

  assign top_value   = m_tdata[VALUE_W-1:0];
  assign stack_count = m_tdata[VALUE_W +: COUNT_OUT_W];
  assign error_code  = m_tdata[VALUE_W+COUNT_OUT_W +: ERR_W];

  a_done_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> error_code == ERR_OK)
    else $error("expression done reported with an error");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && stack_count == '0 && STACK_DEPTH < 128 |-> top_value == '0)
    else $error("empty stack reports a nonzero top");

  a_over_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && error_code == ERR_OVER |-> stack_count == COUNT_OUT_W'(STACK_DEPTH))
    else $error("overflow reported on a stack that is not full");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result word changed");

endmodule

bind dwarf_expression_stack_machine desm_checker #(.STACK_DEPTH(STACK_DEPTH)) u_checker (.*);

/* verif/testbench.sv */
// Self-checking stream testbench for the DWARF expression stack machine.
module testbench;
  import desm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH = DEFAULT_STACK_DEPTH;
  localparam logic [CMD_W-1:0] OP_DEREF_SIZE = 8'h94;
  localparam logic [CMD_W-1:0] OP_UNKNOWN    = 8'hff;

  typedef struct packed {
    logic               last;
    logic               clr;
    logic [VALUE_W-1:0] ext;
    logic [VALUE_W-1:0] operand;
    logic [CMD_W-1:0]   cmd;
  } op_word_t;

  typedef struct packed {
    logic                   done;
    logic [ERR_W-1:0]       err;
    logic [COUNT_OUT_W-1:0] count;
    logic [VALUE_W-1:0]     top;
  } op_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // command, operand, external_value, clear_stack
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // top_value, stack_count, error_code
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [VALUE_W-1:0]    cfg_data = '0;

  dwarf_expression_stack_machine #(.STACK_DEPTH(STACK_DEPTH)) dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // context registers as the machine sees them
  logic [VALUE_W-1:0] fbreg_base_q = '0;
  logic [VALUE_W-1:0] object_base_q = '0;
  logic               has_object_q = 1'b0;
  logic               has_cursor_q = 1'b0;
  logic               has_mem_q = 1'b0;

  logic [VALUE_W-1:0] model_stack [STACK_DEPTH];
  int                 model_depth = 0;
  logic [VALUE_W-1:0] plan_stack [STACK_DEPTH];
  int                 plan_depth = 0;

  op_word_t   pending_ops [$];
  op_result_t expected_results [$];
  int         ops_queued = 0;
  int         ops_accepted = 0;
  int         mismatches = 0;
  int         fill_left = 0;

  bit         in_taken = 1'b0;
  bit         out_taken = 1'b0;
  bit         cfg_taken = 1'b0;
  int         in_wait = 0;
  int         in_run = 0;
  int         out_wait = 0;
  int         out_run = 0;
  op_word_t   drive_op;
  op_word_t   seen_op;
  op_result_t seen_res;
  op_result_t want_res;

  function automatic op_result_t stack_machine_step(ref logic [VALUE_W-1:0] stk [STACK_DEPTH],
                                                    ref int depth, input op_word_t w);
    op_result_t         res;
    logic [ERR_W-1:0]   err;
    logic               push;
    logic [VALUE_W-1:0] pv;
    logic [VALUE_W-1:0] a;
    logic [VALUE_W-1:0] b;
    err = ERR_OK;
    push = 1'b0;
    pv = '0;
    if (w.clr) depth = 0;
    if (w.cmd >= OP_LIT_LO && w.cmd <= OP_LIT_HI) begin
      push = 1'b1;
      pv = VALUE_W'(w.cmd - OP_LIT_LO);
    end else if (w.cmd >= OP_CONST_LO && w.cmd <= OP_CONST_HI) begin
      push = 1'b1;
      pv = w.operand;
    end else if (w.cmd >= OP_BREG_LO && w.cmd <= OP_BREG_HI) begin
      if (!has_cursor_q) err = ERR_NO_BREG;
      else begin
        push = 1'b1;
        pv = w.ext + w.operand;
      end
    end else begin
      case (w.cmd)
        OP_CFA: begin
          if (!has_cursor_q) err = ERR_NO_CFA;
          else begin
            push = 1'b1;
            pv = w.ext;
          end
        end
        OP_FBREG: begin
          push = 1'b1;
          pv = fbreg_base_q + w.operand;
        end
        OP_ADDR: begin
          if (!has_object_q) err = ERR_NO_BASE;
          else begin
            push = 1'b1;
            pv = object_base_q + w.operand;
          end
        end
        OP_DUP: begin
          if (depth < 1) err = ERR_UNDER;
          else begin
            push = 1'b1;
            pv = stk[depth-1];
          end
        end
        OP_DROP: begin
          if (depth < 1) err = ERR_UNDER;
          else depth--;
        end
        OP_OVER: begin
          if (depth < 2) err = ERR_UNDER;
          else begin
            push = 1'b1;
            pv = stk[depth-2];
          end
        end
        OP_SWAP: begin
          if (depth < 2) err = ERR_UNDER;
          else begin
            a = stk[depth-1];
            stk[depth-1] = stk[depth-2];
            stk[depth-2] = a;
          end
        end
        OP_AND, OP_MINUS, OP_MUL, OP_OR, OP_PLUS, OP_XOR: begin
          if (depth < 2) err = ERR_UNDER;
          else begin
            a = stk[depth-1];
            b = stk[depth-2];
            case (w.cmd)
              OP_AND:   pv = a & b;
              OP_MINUS: pv = b - a;
              OP_MUL:   pv = a * b;
              OP_OR:    pv = a | b;
              OP_PLUS:  pv = a + b;
              default:  pv = a ^ b;
            endcase
            depth--;
            stk[depth-1] = pv;
          end
        end
        OP_NEG, OP_NOT, OP_PLUS_UCONST, OP_DEREF: begin
          if (w.cmd == OP_DEREF && !has_mem_q) err = ERR_NO_MEM;
          else if (depth < 1) err = ERR_UNDER;
          else begin
            case (w.cmd)
              OP_NEG:         stk[depth-1] = '0 - stk[depth-1];
              OP_NOT:         stk[depth-1] = ~stk[depth-1];
              OP_PLUS_UCONST: stk[depth-1] = stk[depth-1] + w.operand;
              default:        stk[depth-1] = w.ext;
            endcase
          end
        end
        OP_NOP: ;
        default: err = ERR_UNSUPPORTED;
      endcase
    end
    if (push) begin
      if (depth >= STACK_DEPTH) err = ERR_OVER;
      else begin
        stk[depth] = pv;
        depth++;
      end
    end
    res.top = (depth > 0) ? stk[depth-1] : '0;
    res.count = COUNT_OUT_W'(depth);
    res.err = err;
    res.done = w.last && (err == ERR_OK);
    return res;
  endfunction

  function automatic int draw_wait(ref int run_left);
    if (run_left > 0) begin
      run_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) run_left = $urandom_range(10, 30);
    return $urandom_range(0, 4);
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return VALUE_W'($urandom_range(0, 255));
      3: return {1'b1, {(VALUE_W-1){1'b0}}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic op_word_t mk_op(logic [CMD_W-1:0] cmd, logic [VALUE_W-1:0] operand = '0,
                                     logic [VALUE_W-1:0] ext = '0, logic clr = 1'b0,
                                     logic last = 1'b0);
    op_word_t w;
    w.cmd = cmd;
    w.operand = operand;
    w.ext = ext;
    w.clr = clr;
    w.last = last;
    return w;
  endfunction

  // mostly well-formed expressions that follow the planned stack depth, some noise
  function automatic op_word_t next_random_op();
    op_word_t w;
    int       sel;
    int       d;
    w.operand = rand_value();
    w.ext = rand_value();
    w.last = ($urandom_range(0, 7) == 0);
    w.clr = 1'b0;
    if (fill_left > 0) begin
      fill_left--;
      w.cmd = $urandom_range(0, 1) ? OP_LIT_LO + CMD_W'($urandom_range(0, 31))
                                   : OP_CONST_LO + CMD_W'($urandom_range(0, 9));
      return w;
    end
    sel = $urandom_range(0, 99);
    if (sel < 2) begin
      fill_left = STACK_DEPTH + 2;
      w.cmd = OP_DUP;
    end else if (sel < 7) begin
      w.cmd = CMD_W'($urandom_range(0, 255));
      w.clr = 1'($urandom_range(0, 1));
    end else begin
      w.clr = (sel < 11);
      d = w.clr ? 0 : plan_depth;
      if (d == 0 || (d < 2 && $urandom_range(0, 1) == 0) ||
          (d < STACK_DEPTH - 4 && $urandom_range(0, 2) == 0)) begin
        case ($urandom_range(0, 5))
          0: w.cmd = OP_LIT_LO + CMD_W'($urandom_range(0, 31));
          1: w.cmd = OP_CONST_LO + CMD_W'($urandom_range(0, 9));
          2: w.cmd = OP_FBREG;
          3: w.cmd = OP_ADDR;
          4: w.cmd = OP_BREG_LO + CMD_W'($urandom_range(0, 31));
          default: w.cmd = OP_CFA;
        endcase
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: begin
            case ($urandom_range(0, 5))
              0: w.cmd = OP_AND;
              1: w.cmd = OP_MINUS;
              2: w.cmd = OP_MUL;
              3: w.cmd = OP_OR;
              4: w.cmd = OP_PLUS;
              default: w.cmd = OP_XOR;
            endcase
          end
          4, 5: begin
            case ($urandom_range(0, 3))
              0: w.cmd = OP_NEG;
              1: w.cmd = OP_NOT;
              2: w.cmd = OP_PLUS_UCONST;
              default: w.cmd = OP_DEREF;
            endcase
          end
          6: w.cmd = OP_DUP;
          7: w.cmd = OP_DROP;
          8: w.cmd = $urandom_range(0, 1) ? OP_OVER : OP_SWAP;
          default: w.cmd = OP_NOP;
        endcase
      end
    end
    return w;
  endfunction

  task automatic queue_op(op_word_t w);
    void'(stack_machine_step(plan_stack, plan_depth, w));
    pending_ops.push_back(w);
    ops_queued++;
  endtask

  task automatic drain();
    while (ops_accepted != ops_queued || expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  // input side
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (in_wait > 0) begin
        in_wait--;
        s_tvalid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        drive_op = pending_ops.pop_front();
        s_tdata <= IN_DATA_W'({drive_op.clr, drive_op.ext, drive_op.operand, drive_op.cmd});
        s_tlast <= drive_op.last;
        s_tvalid <= 1'b1;
        in_wait = draw_wait(in_run);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // output side
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (out_taken) out_wait = draw_wait(out_run);
      if (out_wait > 0) begin
        out_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    in_taken = !rst && s_tvalid && s_tready;
    out_taken = !rst && m_tvalid && m_tready;
    cfg_taken = !rst && cfg_valid && cfg_ready;
    if (cfg_taken) begin
      case (cfg_index)
        REG_FBREG_BASE:     fbreg_base_q = cfg_data;
        REG_OBJECT_BASE:    object_base_q = cfg_data;
        REG_HAS_OBJECT:     has_object_q = cfg_data[0];
        REG_HAS_CURSOR:     has_cursor_q = cfg_data[0];
        REG_HAS_ADDR_SPACE: has_mem_q = cfg_data[0];
        default: ;
      endcase
    end
    if (in_taken) begin
      seen_op.cmd = s_tdata[IN_CMD_LSB +: CMD_W];
      seen_op.operand = s_tdata[IN_OPND_LSB +: VALUE_W];
      seen_op.ext = s_tdata[IN_EXT_LSB +: VALUE_W];
      seen_op.clr = s_tdata[IN_CLR_BIT];
      seen_op.last = s_tlast;
      expected_results.push_back(stack_machine_step(model_stack, model_depth, seen_op));
      ops_accepted++;
    end
    if (out_taken) begin
      seen_res.top = m_tdata[VALUE_W-1:0];
      seen_res.count = m_tdata[VALUE_W +: COUNT_OUT_W];
      seen_res.err = m_tdata[VALUE_W+COUNT_OUT_W +: ERR_W];
      seen_res.done = m_tlast;
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: %h", seen_res);
        mismatches++;
      end else begin
        want_res = expected_results.pop_front();
        if (seen_res.top !== want_res.top) begin
          $error("top_value: expected %h, got %h", want_res.top, seen_res.top);
          mismatches++;
        end
        if (seen_res.count !== want_res.count) begin
          $error("stack_count: expected %0d, got %0d", want_res.count, seen_res.count);
          mismatches++;
        end
        if (seen_res.err !== want_res.err) begin
          $error("error_code: expected %0d, got %0d", want_res.err, seen_res.err);
          mismatches++;
        end
        if (seen_res.done !== want_res.done) begin
          $error("expression_done: expected %b, got %b", want_res.done, seen_res.done);
          mismatches++;
        end
      end
    end
  end

  initial begin
    #3ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // reset context: every context op but fbreg fails
    queue_op(mk_op(OP_DROP));
    queue_op(mk_op(OP_LIT_LO));
    queue_op(mk_op(OP_LIT_HI));
    queue_op(mk_op(OP_CONST_LO, '1));
    queue_op(mk_op(OP_CONST_HI, {1'b1, {(VALUE_W-1){1'b0}}}));
    queue_op(mk_op(OP_ADDR, 64'h10));
    queue_op(mk_op(OP_BREG_LO, 64'h1, 64'h2));
    queue_op(mk_op(OP_CFA, '0, 64'h3));
    queue_op(mk_op(OP_DEREF, '0, 64'h4));
    queue_op(mk_op(OP_DEREF_SIZE, 64'h8));
    queue_op(mk_op(OP_UNKNOWN, '1, '1, 1'b1, 1'b1));
    queue_op(mk_op(OP_DEREF, '0, '1, 1'b1));
    queue_op(mk_op(OP_FBREG, 64'h5, '0, 1'b0, 1'b1));
    drain();

    write_reg(REG_FBREG_BASE, '1);
    write_reg(REG_OBJECT_BASE, '1);
    write_reg(REG_HAS_OBJECT, 64'h1);
    write_reg(REG_HAS_CURSOR, 64'h1);
    write_reg(REG_HAS_ADDR_SPACE, 64'h1);
    queue_op(mk_op(OP_FBREG, 64'h1, '0, 1'b1));
    queue_op(mk_op(OP_ADDR, 64'h2));
    queue_op(mk_op(OP_BREG_HI, 64'h5, '1));
    queue_op(mk_op(OP_CFA, '0, 64'hfedc_ba98_7654_3210));
    queue_op(mk_op(OP_DEREF, '0, 64'h0123_4567_89ab_cdef));
    queue_op(mk_op(OP_DUP));
    queue_op(mk_op(OP_OVER));
    queue_op(mk_op(OP_SWAP));
    queue_op(mk_op(OP_PLUS));
    queue_op(mk_op(OP_MINUS));
    queue_op(mk_op(OP_MUL));
    queue_op(mk_op(OP_AND));
    queue_op(mk_op(OP_OR));
    queue_op(mk_op(OP_XOR));
    queue_op(mk_op(OP_NOT));
    queue_op(mk_op(OP_NEG));
    queue_op(mk_op(OP_PLUS_UCONST, '1));
    queue_op(mk_op(OP_NOP, '0, '0, 1'b0, 1'b1));
    queue_op(mk_op(OP_PLUS, '0, '0, 1'b1));
    queue_op(mk_op(OP_LIT_LO + 8'd3));
    queue_op(mk_op(OP_SWAP, '0, '0, 1'b0, 1'b1));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_FBREG_BASE, rand_value());
      write_reg(REG_OBJECT_BASE, rand_value());
      write_reg(REG_HAS_OBJECT, (ph == 0) ? 64'h1 : VALUE_W'($urandom_range(0, 3) != 0));
      write_reg(REG_HAS_CURSOR, (ph == 0) ? 64'h1 : VALUE_W'($urandom_range(0, 3) != 0));
      write_reg(REG_HAS_ADDR_SPACE, (ph == 0) ? 64'h1 : VALUE_W'($urandom_range(0, 3) != 0));
      for (int n = 0; n < 80 || fill_left > 0; n++) queue_op(next_random_op());
      drain();
    end

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
